@@ hdl/pipct_pkg.sv @@
// ----------------------------------------------------------------------------
// Point-in-polygon crossing test package
// Shared constant for the crossing test and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package pipct_pkg;

	// Default width of one signed coordinate in font units.
	localparam int COORD_BITS_DEFAULT = 16;

endpackage : pipct_pkg

`default_nettype wire

@@ hdl/pipct_if.sv @@
// ----------------------------------------------------------------------------
// Point-in-polygon crossing test channels
// Valid/ready channels for edge items coming in and inside/outside results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pipct_in_if #(
	parameter int COORD_BITS = pipct_pkg::COORD_BITS_DEFAULT
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] query_x;
	logic signed [COORD_BITS-1:0] query_y;
	logic signed [COORD_BITS-1:0] edge_start_x;
	logic signed [COORD_BITS-1:0] edge_start_y;
	logic signed [COORD_BITS-1:0] edge_end_x;
	logic signed [COORD_BITS-1:0] edge_end_y;
	logic                         last_edge;

	modport source (
		output valid, query_x, query_y, edge_start_x, edge_start_y,
		       edge_end_x, edge_end_y, last_edge,
		input  ready
	);
	modport sink (
		input  valid, query_x, query_y, edge_start_x, edge_start_y,
		       edge_end_x, edge_end_y, last_edge,
		output ready
	);
endinterface : pipct_in_if

interface pipct_out_if;
	logic valid;
	logic ready;
	logic inside_res;

	modport source (
		output valid, inside_res,
		input  ready
	);
	modport sink (
		input  valid, inside_res,
		output ready
	);
endinterface : pipct_out_if

`default_nettype wire

@@ hdl/point_in_polygon_crossing_test.sv @@
// ----------------------------------------------------------------------------
// Point-in-polygon crossing test
// Even-odd ray casting over a stream of polygon edges, one edge per item.
// ----------------------------------------------------------------------------
// The block takes one edge item per clock cycle and keeps taking them while a
// result waits at the output, stopping only when a closing edge has to leave
// the last stage and the output register is still full. Each item passes an
// input register, a stage that forms the edge classification and three exact
// products of coordinate differences, and a stage that finishes the crossing
// compare and toggles the parity bit; the inside/outside result of a closing
// edge is then registered in the output register. Edges that give no result
// still take an input slot each, just as a closing edge does.
`default_nettype none

module point_in_polygon_crossing_test #(
	parameter int COORD_BITS = pipct_pkg::COORD_BITS_DEFAULT
) (
	input  wire          clk,
	input  wire          arst_n,
	pipct_in_if.sink     edges,
	pipct_out_if.source  result
);

	localparam int DW = COORD_BITS + 1;   // coordinate differences
	localparam int HW = COORD_BITS + 2;   // ray height, at most 2^COORD_BITS
	localparam int PW = DW + HW;          // products and their difference

	typedef struct packed {
		logic force_cross;   // endpoint on the ray above the point
		logic gen_pos;       // general edge, rising in x, point strictly between
		logic gen_neg;       // general edge, falling in x, point within range
		logic last;
	} flags_t;

	// Stage 1: input register.
	logic                         valid_s1;
	logic signed [COORD_BITS-1:0] px_s1, py_s1, ax_s1, ay_s1, bx_s1, by_s1;
	logic                         last_s1;

	// Stage 2: products and classification.
	logic                valid_s2;
	flags_t              flags_s2;
	logic signed [PW-1:0] dxsy_s2, dysx_s2, den_s2;

	logic crossing_parity_q;
	logic out_valid_q;
	logic inside_q;

	logic stall, adv2, load_s1;

	assign stall   = valid_s2 && flags_s2.last && out_valid_q && !result.ready;
	assign adv2    = !stall;
	assign load_s1 = adv2 || !valid_s1;

	assign edges.ready       = load_s1;
	assign result.valid      = out_valid_q;
	assign result.inside_res = inside_q;

	// ---------------- stage 1 logic ----------------
	logic signed [DW-1:0] px_e, py_e, ax_e, ay_e, bx_e, by_e;
	logic signed [DW-1:0] sx, sy, dx, dy, ndx;
	logic signed [COORD_BITS-1:0] ymax;
	logic signed [HW-1:0] h;
	logic skip, force_cross, general;
	flags_t flags_d;

	always_comb begin
		px_e = DW'(px_s1);
		py_e = DW'(py_s1);
		ax_e = DW'(ax_s1);
		ay_e = DW'(ay_s1);
		bx_e = DW'(bx_s1);
		by_e = DW'(by_s1);
		sx   = px_e - ax_e;
		sy   = py_e - ay_e;
		dx   = bx_e - ax_e;
		dy   = by_e - ay_e;
		ndx  = ax_e - bx_e;

		ymax = py_s1;
		if (ay_s1 > ymax) begin
			ymax = ay_s1;
		end
		if (by_s1 > ymax) begin
			ymax = by_s1;
		end
		// The ray runs one unit above the highest of the point and both endpoints.
		h = HW'(ymax) + HW'(1) - HW'(py_s1);

		skip = (py_s1 > ay_s1 && py_s1 > by_s1) ||
		       (px_s1 > ax_s1 && px_s1 > bx_s1) ||
		       (px_s1 < ax_s1 && px_s1 < bx_s1) ||
		       (px_s1 == ax_s1 && px_s1 == bx_s1) ||
		       (px_s1 == ax_s1 && px_s1 > bx_s1) ||
		       (px_s1 == bx_s1 && px_s1 > ax_s1);
		force_cross = !skip && py_s1 < ay_s1 && py_s1 < by_s1 &&
		              ((px_s1 == ax_s1 && px_s1 < bx_s1) ||
		               (px_s1 == bx_s1 && px_s1 < ax_s1));
		general = !skip && !force_cross;

		// With a positive ray height, the ray parameter test reduces to these
		// ranges of sx against dx.
		flags_d.force_cross = force_cross;
		flags_d.gen_pos     = general && dx > 0 && sx > 0 && sx < dx;
		flags_d.gen_neg     = general && dx < 0 && sx <= 0 && sx >= dx;
		flags_d.last        = last_s1;
	end

	// ---------------- stage 2 logic ----------------
	logic signed [PW-1:0] tn;
	logic edge_hit, parity_next;

	always_comb begin
		tn       = dxsy_s2 - dysx_s2;
		edge_hit = flags_s2.force_cross ||
		           (flags_s2.gen_pos && tn < 0 && den_s2 < tn) ||
		           (flags_s2.gen_neg && tn >= 0 && tn <= den_s2);
		parity_next = crossing_parity_q ^ edge_hit;
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= edges.valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && edges.valid) begin
			px_s1   <= edges.query_x;
			py_s1   <= edges.query_y;
			ax_s1   <= edges.edge_start_x;
			ay_s1   <= edges.edge_start_y;
			bx_s1   <= edges.edge_end_x;
			by_s1   <= edges.edge_end_y;
			last_s1 <= edges.last_edge;
		end
		if (adv2 && valid_s1) begin
			flags_s2 <= flags_d;
			dxsy_s2  <= PW'(dx * sy);
			dysx_s2  <= PW'(dy * sx);
			den_s2   <= PW'(ndx * h);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crossing_parity_q <= 1'b0;
			out_valid_q       <= 1'b0;
			inside_q          <= 1'b0;
		end else begin
			if (valid_s2 && adv2) begin
				if (flags_s2.last) begin
					inside_q          <= parity_next;
					crossing_parity_q <= 1'b0;
				end else begin
					crossing_parity_q <= parity_next;
				end
			end
			if (valid_s2 && adv2 && flags_s2.last) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- assertions ----------------
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && adv2 && flags_s2.last) |=> out_valid_q)
		else $error("closing edge did not load the output register");

	a_parity_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && adv2 && flags_s2.last) |=> !crossing_parity_q)
		else $error("parity not cleared after closing edge");

	a_skip_holds_parity: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && adv2 && !flags_s2.last && !flags_s2.force_cross &&
		 !flags_s2.gen_pos && !flags_s2.gen_neg) |=> $stable(crossing_parity_q))
		else $error("skipped edge changed the parity");

	a_stall_needs_full_output: assert property (@(posedge clk) disable iff (!arst_n)
		stall |-> (out_valid_q && valid_s2))
		else $error("pipeline stalled without a pending result");

	a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!edges.ready |-> (valid_s1 && stall))
		else $error("input refused while the pipeline could move");

endmodule : point_in_polygon_crossing_test

`default_nettype wire
